@@ sv/ihv_pkg.sv @@
// ----------------------------------------------------------------------------
// IPv4 header validator package
// Shared types, status codes and sizing constants for the validator blocks.
// ----------------------------------------------------------------------------
package ihv_pkg;

  // Number of bytes in an IPv4 header without options.
  localparam int unsigned HdrBytes = 20;
  localparam int unsigned PosW     = 5;

  // Default depths of the two internal queues.
  localparam int unsigned MidDepthDef = 2;
  localparam int unsigned OutDepthDef = 2;

  // Result status codes.
  localparam logic [2:0] STATUS_OK       = 3'd0;
  localparam logic [2:0] STATUS_SHORT    = 3'd1;
  localparam logic [2:0] STATUS_VERSION  = 3'd2;
  localparam logic [2:0] STATUS_LENGTH   = 3'd3;
  localparam logic [2:0] STATUS_FRAGMENT = 3'd4;
  localparam logic [2:0] STATUS_CHECKSUM = 3'd5;

  // Header field constants.
  localparam logic [3:0]  IP_VERSION4   = 4'd4;
  localparam logic [3:0]  IP_IHL5       = 4'd5;
  localparam logic [15:0] FLAG_MF       = 16'h2000;
  localparam logic [15:0] FRAG_OFS_MASK = 16'h1FFF;
  localparam logic [15:0] SUM_ALL_ONES  = 16'hFFFF;

  // Input request: one byte of the received buffer.
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_byte;
    logic [15:0] buffer_length;
  } in_req_t;

  // Result request: header fields and check status.
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [7:0]  protocol;
    logic [7:0]  hop_limit;
    logic [15:0] total_length;
    logic [15:0] ident;
    logic [15:0] flags_fragment;
    logic [15:0] payload_length;
  } res_t;

  // Kind of a classified byte handed from the front to the back.
  typedef enum logic {
    KIND_SHORT,
    KIND_HDR
  } kind_e;

  // Classified byte travelling through the middle queue.
  typedef struct packed {
    kind_e            kind;
    logic [PosW-1:0]  pos;
    logic [7:0]       data_byte;
    logic [15:0]      buffer_length;
  } item_t;

endpackage

@@ sv/ihv_fifo.sv @@
// ----------------------------------------------------------------------------
// Validator queue
// Small first-in first-out queue of packed items, used between the front and
// the back and again on the result side.
// ----------------------------------------------------------------------------
module ihv_fifo #(
  parameter type         ItemT = logic,
  parameter int unsigned Depth = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  ItemT item_i,
  output logic full_o,
  input  logic pop_i,
  output ItemT item_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  ItemT            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = mem_q[rd_ptr_q];

  // Pointer and fill count updates, wrapping at the queue depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage is written at the write pointer; it needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

@@ sv/ihv_front.sv @@
// ----------------------------------------------------------------------------
// Validator front end
// Accepts received bytes, tracks the header byte position and classifies each
// byte as a short-buffer report, a header byte, or a byte to be dropped.
// ----------------------------------------------------------------------------
module ihv_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  output logic            full,
  input  ihv_pkg::in_req_t in_req_i,
  output logic            item_push_o,
  output ihv_pkg::item_t  item_o,
  input  logic            item_full_i
);

  localparam logic [ihv_pkg::PosW-1:0] HdrEnd = ihv_pkg::PosW'(ihv_pkg::HdrBytes);

  logic [ihv_pkg::PosW-1:0] pos_q, pos_d;
  logic                     accept;
  logic                     is_short;
  logic                     in_header;

  assign full     = item_full_i;
  assign accept   = push && !item_full_i;
  assign is_short = in_req_i.buffer_length < 16'(ihv_pkg::HdrBytes);
  assign in_header = pos_q < HdrEnd;

  // Classify the byte and work out the next header position.
  always_comb begin
    pos_d                 = pos_q;
    item_push_o           = 1'b0;
    item_o.kind           = ihv_pkg::KIND_HDR;
    item_o.pos            = pos_q;
    item_o.data_byte      = in_req_i.data_byte;
    item_o.buffer_length  = in_req_i.buffer_length;
    if (accept) begin
      if (in_req_i.first_byte) begin
        item_push_o = 1'b1;
        if (is_short) begin
          item_o.kind = ihv_pkg::KIND_SHORT;
          pos_d       = HdrEnd;
        end else begin
          item_o.pos = '0;
          pos_d      = ihv_pkg::PosW'(1);
        end
      end else if (in_header) begin
        item_push_o = 1'b1;
        pos_d       = pos_q + 1'b1;
      end
    end
  end

  // The position rests at the header length while no header is in progress.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= HdrEnd;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

@@ sv/ihv_back.sv @@
// ----------------------------------------------------------------------------
// Validator back end
// Captures header fields, keeps the one's-complement header sum and runs the
// header checks once the last header byte is in.
// ----------------------------------------------------------------------------
module ihv_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ihv_pkg::item_t item_i,
  input  logic           item_empty_i,
  output logic           item_pop_o,
  output logic           res_push_o,
  output ihv_pkg::res_t  res_o,
  input  logic           res_full_i
);

  localparam logic [4:0] LastPos = 5'(ihv_pkg::HdrBytes - 1);

  logic [15:0] sum_q, sum_d;
  logic [7:0]  hold_q, hold_d;
  logic [15:0] blen_q, blen_d;
  logic [7:0]  ver_q, ver_d;
  logic [15:0] len_q, len_d;
  logic [15:0] ident_q, ident_d;
  logic [15:0] frag_q, frag_d;
  logic [7:0]  ttl_q, ttl_d;
  logic [7:0]  proto_q, proto_d;
  logic [31:0] src_q, src_d;
  logic [31:0] dst_q, dst_d;

  logic        take;
  logic [16:0] word_sum;
  logic [15:0] sum_fold;
  logic [7:0]  b;
  logic [2:0]  status;

  assign take       = !item_empty_i && !res_full_i;
  assign item_pop_o = take;
  assign b          = item_i.data_byte;

  // Add the completed big-endian word and fold the carry back in.
  assign word_sum = {1'b0, sum_q} + {1'b0, hold_q, b};
  assign sum_fold = word_sum[15:0] + 16'(word_sum[16]);

  // Field capture and sum update for one header byte.
  always_comb begin
    sum_d   = sum_q;
    hold_d  = hold_q;
    blen_d  = blen_q;
    ver_d   = ver_q;
    len_d   = len_q;
    ident_d = ident_q;
    frag_d  = frag_q;
    ttl_d   = ttl_q;
    proto_d = proto_q;
    src_d   = src_q;
    dst_d   = dst_q;
    if (take && item_i.kind == ihv_pkg::KIND_HDR) begin
      if (item_i.pos == '0) begin
        // A new header starts: clear everything from the last one.
        sum_d   = '0;
        blen_d  = item_i.buffer_length;
        len_d   = '0;
        ident_d = '0;
        frag_d  = '0;
        ttl_d   = '0;
        proto_d = '0;
        src_d   = '0;
        dst_d   = '0;
      end
      if (!item_i.pos[0]) begin
        hold_d = b;
      end else begin
        sum_d = sum_fold;
      end
      case (item_i.pos) inside
        5'd0:             ver_d   = b;
        5'd2, 5'd3:       len_d   = {len_q[7:0], b};
        5'd4, 5'd5:       ident_d = {ident_q[7:0], b};
        5'd6, 5'd7:       frag_d  = {frag_q[7:0], b};
        5'd8:             ttl_d   = b;
        5'd9:             proto_d = b;
        5'd12, 5'd13,
        5'd14, 5'd15:     src_d   = {src_q[23:0], b};
        5'd16, 5'd17,
        5'd18, 5'd19:     dst_d   = {dst_q[23:0], b};
        default:          ;
      endcase
    end
  end

  // Header checks, in priority order, at the last header byte.
  always_comb begin
    if (ver_q[7:4] != ihv_pkg::IP_VERSION4 || ver_q[3:0] != ihv_pkg::IP_IHL5) begin
      status = ihv_pkg::STATUS_VERSION;
    end else if (len_q < 16'(ihv_pkg::HdrBytes) || len_q > blen_q) begin
      status = ihv_pkg::STATUS_LENGTH;
    end else if ((frag_q & ihv_pkg::FLAG_MF) != '0
                 || (frag_q & ihv_pkg::FRAG_OFS_MASK) != '0) begin
      status = ihv_pkg::STATUS_FRAGMENT;
    end else if (sum_fold != ihv_pkg::SUM_ALL_ONES) begin
      status = ihv_pkg::STATUS_CHECKSUM;
    end else begin
      status = ihv_pkg::STATUS_OK;
    end
  end

  // Build the result; fields other than status are zero on any failure.
  always_comb begin
    res_push_o = 1'b0;
    res_o      = '0;
    if (take) begin
      if (item_i.kind == ihv_pkg::KIND_SHORT) begin
        res_push_o   = 1'b1;
        res_o.status = ihv_pkg::STATUS_SHORT;
      end else if (item_i.pos == LastPos) begin
        res_push_o   = 1'b1;
        res_o.status = status;
        if (status == ihv_pkg::STATUS_OK) begin
          res_o.src_addr       = src_q;
          res_o.dst_addr       = dst_d;
          res_o.protocol       = proto_q;
          res_o.hop_limit      = ttl_q;
          res_o.total_length   = len_q;
          res_o.ident          = ident_q;
          res_o.flags_fragment = frag_q;
          res_o.payload_length = len_q - 16'(ihv_pkg::HdrBytes);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      hold_q  <= '0;
      blen_q  <= '0;
      ver_q   <= '0;
      len_q   <= '0;
      ident_q <= '0;
      frag_q  <= '0;
      ttl_q   <= '0;
      proto_q <= '0;
      src_q   <= '0;
      dst_q   <= '0;
    end else begin
      sum_q   <= sum_d;
      hold_q  <= hold_d;
      blen_q  <= blen_d;
      ver_q   <= ver_d;
      len_q   <= len_d;
      ident_q <= ident_d;
      frag_q  <= frag_d;
      ttl_q   <= ttl_d;
      proto_q <= proto_d;
      src_q   <= src_d;
      dst_q   <= dst_d;
    end
  end

endmodule

@@ sv/ipv4_header_validator_top.sv @@
// ----------------------------------------------------------------------------
// IPv4 header validator
// Parses a received buffer one byte per request and reports header status.
// ----------------------------------------------------------------------------
// Throughput: one byte request per cycle while neither queue is full, set by
// the add and capture in the back end. A result passes through the middle
// queue, then the result queue, before it is visible on the result ports.
// Reset is asynchronous and active low; it empties both queues and leaves
// the block waiting for a marked first byte.
module ipv4_header_validator_top #(
  parameter int unsigned MidDepth = ihv_pkg::MidDepthDef,
  parameter int unsigned OutDepth = ihv_pkg::OutDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  ihv_pkg::in_req_t in_req_i,
  output logic             empty,
  input  logic             pop,
  output ihv_pkg::res_t    res_o
);

  logic           item_push, item_full, item_empty, item_pop;
  ihv_pkg::item_t item_in, item_out;
  logic           res_push, res_full;
  ihv_pkg::res_t  res_in;

  // Front end: position tracking and classification.
  ihv_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_req_i    (in_req_i),
    .item_push_o (item_push),
    .item_o      (item_in),
    .item_full_i (item_full)
  );

  // Queue of classified bytes between front and back.
  ihv_fifo #(
    .ItemT (ihv_pkg::item_t),
    .Depth (MidDepth)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (item_push),
    .item_i  (item_in),
    .full_o  (item_full),
    .pop_i   (item_pop),
    .item_o  (item_out),
    .empty_o (item_empty)
  );

  // Back end: capture, checksum and checks.
  ihv_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item_out),
    .item_empty_i (item_empty),
    .item_pop_o   (item_pop),
    .res_push_o   (res_push),
    .res_o        (res_in),
    .res_full_i   (res_full)
  );

  // Result queue towards the consumer.
  ihv_fifo #(
    .ItemT (ihv_pkg::res_t),
    .Depth (OutDepth)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .item_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .item_o  (res_o),
    .empty_o (empty)
  );

endmodule

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// IPv4 header validator testbench
// Streams buffers byte by byte into the validator and checks every result
// request against a cycle-free model of the header checks. Half of the random
// part is well-formed headers with random content. The rest are headers
// that break one check each, short buffers, cut-off headers and stray bytes.
// Both sides idle at random. The receiver also holds off once for a long
// stretch, and the sender drains the block at a few points.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned TargetBytes   = 1450;
  localparam int unsigned IdlePct       = 34;
  localparam int unsigned DrainEvery    = 300;
  localparam int unsigned HoldStart     = 800;
  localparam int unsigned HoldCycles    = 400;
  localparam int unsigned QuietFrom     = 1500;
  localparam int unsigned QuietTo       = 2000;
  localparam int unsigned TailCycles    = 10;
  localparam int unsigned WatchdogLimit = 3000;

  // One pending byte request; drain holds it back until no result is owed.
  typedef struct {
    ihv_pkg::in_req_t req;
    bit               drain;
  } byte_slot_t;

  logic             clk_i    = 1'b0;
  logic             rst_ni   = 1'b0;
  logic             push     = 1'b0;
  logic             pop      = 1'b0;
  ihv_pkg::in_req_t in_req_i = '0;
  logic             full;
  logic             empty;
  ihv_pkg::res_t    res_o;

  ipv4_header_validator_top uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .in_req_i (in_req_i),
    .empty    (empty),
    .pop      (pop),
    .res_o    (res_o)
  );

  // Stimulus and expected results.
  byte_slot_t     byte_queue [$];
  ihv_pkg::res_t  header_results [$];
  logic [7:0]     hdr_buf [ihv_pkg::HdrBytes];
  bit             drain_next;
  int unsigned    n_useful;
  int unsigned    n_total;
  int unsigned    n_accepted;
  int unsigned    n_checked;
  int unsigned    n_errors;
  int unsigned    status_seen [8];
  int unsigned    drv_cyc;
  int unsigned    mon_cyc;
  int unsigned    hold_left;
  int unsigned    stall_cycles;

  // Model of the parser state.
  logic [ihv_pkg::PosW-1:0] hdr_pos;
  logic [15:0]              hdr_sum;
  logic [7:0]               hi_hold;
  logic [15:0]              buf_len;
  logic [7:0]               ver_ihl;
  logic [15:0]              tot_len;
  logic [15:0]              ident_w;
  logic [15:0]              frag_w;
  logic [7:0]               ttl;
  logic [7:0]               proto;
  logic [31:0]              src;
  logic [31:0]              dst;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // One's-complement addition with end-around carry.
  function automatic logic [15:0] fold_add(input logic [15:0] acc, input logic [15:0] word);
    logic [16:0] s;
    s = {1'b0, acc} + {1'b0, word};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  function automatic bit quiet(input int unsigned cyc);
    return cyc >= QuietFrom && cyc < QuietTo;
  endfunction

  task automatic clear_header();
    hdr_sum = '0;
    hi_hold = '0;
    ver_ihl = '0;
    tot_len = '0;
    ident_w = '0;
    frag_w  = '0;
    ttl     = '0;
    proto   = '0;
    src     = '0;
    dst     = '0;
  endtask

  // Advance the model by one accepted byte and record any result it causes.
  task automatic track_byte(input ihv_pkg::in_req_t req);
    ihv_pkg::res_t            r;
    logic [ihv_pkg::PosW-1:0] p;
    logic [7:0]               b;
    r = '0;
    b = req.data_byte;
    if (req.first_byte) begin
      buf_len = req.buffer_length;
      clear_header();
      if (req.buffer_length < ihv_pkg::HdrBytes) begin
        hdr_pos  = ihv_pkg::PosW'(ihv_pkg::HdrBytes);
        r.status = ihv_pkg::STATUS_SHORT;
        header_results.push_back(r);
        return;
      end
      hdr_pos = '0;
    end else if (hdr_pos >= ihv_pkg::HdrBytes) begin
      return;
    end
    p = hdr_pos;
    if (!p[0]) hi_hold = b;
    else hdr_sum = fold_add(hdr_sum, {hi_hold, b});
    case (p) inside
      5'd0: ver_ihl = b;
      5'd2, 5'd3: tot_len = {tot_len[7:0], b};
      5'd4, 5'd5: ident_w = {ident_w[7:0], b};
      5'd6, 5'd7: frag_w = {frag_w[7:0], b};
      5'd8: ttl = b;
      5'd9: proto = b;
      5'd12, 5'd13, 5'd14, 5'd15: src = {src[23:0], b};
      5'd16, 5'd17, 5'd18, 5'd19: dst = {dst[23:0], b};
      default: ;
    endcase
    hdr_pos = p + 1'b1;
    if (p != ihv_pkg::PosW'(ihv_pkg::HdrBytes - 1)) return;
    // Checks in priority order once the last header byte is in.
    if (ver_ihl[7:4] != ihv_pkg::IP_VERSION4 || ver_ihl[3:0] != ihv_pkg::IP_IHL5)
      r.status = ihv_pkg::STATUS_VERSION;
    else if (tot_len < ihv_pkg::HdrBytes || tot_len > buf_len)
      r.status = ihv_pkg::STATUS_LENGTH;
    else if ((frag_w & ihv_pkg::FLAG_MF) != 0 || (frag_w & ihv_pkg::FRAG_OFS_MASK) != 0)
      r.status = ihv_pkg::STATUS_FRAGMENT;
    else if (hdr_sum != ihv_pkg::SUM_ALL_ONES)
      r.status = ihv_pkg::STATUS_CHECKSUM;
    else
      r.status = ihv_pkg::STATUS_OK;
    if (r.status == ihv_pkg::STATUS_OK) begin
      r.src_addr       = src;
      r.dst_addr       = dst;
      r.protocol       = proto;
      r.hop_limit      = ttl;
      r.total_length   = tot_len;
      r.ident          = ident_w;
      r.flags_fragment = frag_w;
      r.payload_length = tot_len - 16'(ihv_pkg::HdrBytes);
    end
    header_results.push_back(r);
  endtask

  // Fill the header buffer with a well-formed header and a correct checksum.
  task automatic build_header(input logic [15:0] tot, input logic [15:0] frag);
    logic [15:0] sum;
    int unsigned i;
    hdr_buf[0] = {ihv_pkg::IP_VERSION4, ihv_pkg::IP_IHL5};
    hdr_buf[1] = 8'($urandom);
    {hdr_buf[2], hdr_buf[3]} = tot;
    {hdr_buf[4], hdr_buf[5]} = 16'($urandom);
    {hdr_buf[6], hdr_buf[7]} = frag;
    for (i = 8; i < ihv_pkg::HdrBytes; i++) hdr_buf[i] = 8'($urandom);
    hdr_buf[10] = 8'h00;
    hdr_buf[11] = 8'h00;
    sum = '0;
    for (i = 0; i < ihv_pkg::HdrBytes; i += 2)
      sum = fold_add(sum, {hdr_buf[i], hdr_buf[i + 1]});
    {hdr_buf[10], hdr_buf[11]} = ~sum;
  endtask

  // Queue the first count header bytes, then tail unmarked random bytes.
  task automatic queue_bytes(input logic [15:0] blen, input int unsigned count,
                             input int unsigned tail);
    byte_slot_t  slot;
    int unsigned i;
    for (i = 0; i < count + tail; i++) begin
      slot.req.data_byte     = (i < count) ? hdr_buf[i] : 8'($urandom);
      slot.req.first_byte    = (i == 0 && count != 0);
      slot.req.buffer_length = slot.req.first_byte ? blen : 16'($urandom);
      slot.drain             = drain_next;
      drain_next             = 1'b0;
      byte_queue.push_back(slot);
    end
    n_useful += count;
  endtask

  // One random buffer: half well-formed, the rest bad, short, cut off or stray.
  task automatic queue_random_buffer();
    int unsigned pick;
    logic [15:0] blen;
    logic [15:0] tot;
    logic [15:0] frag;
    logic [7:0]  v;
    pick = $urandom_range(99);
    blen = 16'($urandom_range(65535, ihv_pkg::HdrBytes));
    case ($urandom_range(7))
      0: tot = 16'(ihv_pkg::HdrBytes);
      1: tot = blen;
      default: tot = 16'($urandom_range(blen, ihv_pkg::HdrBytes));
    endcase
    frag = {2'($urandom), 14'd0};
    build_header(tot, frag);
    if (pick < 50) begin
      queue_bytes(blen, ihv_pkg::HdrBytes, $urandom_range(4));
    end else if (pick < 58) begin
      do v = 8'($urandom); while (v == {ihv_pkg::IP_VERSION4, ihv_pkg::IP_IHL5});
      hdr_buf[0] = v;
      queue_bytes(blen, ihv_pkg::HdrBytes, $urandom_range(2));
    end else if (pick < 66) begin
      if (blen == 16'hFFFF || $urandom_range(1) == 0)
        tot = 16'($urandom_range(ihv_pkg::HdrBytes - 1, 0));
      else tot = 16'($urandom_range(65535, int'(blen) + 1));
      build_header(tot, frag);
      queue_bytes(blen, ihv_pkg::HdrBytes, $urandom_range(2));
    end else if (pick < 74) begin
      frag = 16'($urandom);
      if ((frag & (ihv_pkg::FLAG_MF | ihv_pkg::FRAG_OFS_MASK)) == 0)
        frag = frag | ihv_pkg::FLAG_MF;
      build_header(tot, frag);
      queue_bytes(blen, ihv_pkg::HdrBytes, $urandom_range(2));
    end else if (pick < 82) begin
      hdr_buf[10 + $urandom_range(1)] ^= 8'($urandom_range(255, 1));
      queue_bytes(blen, ihv_pkg::HdrBytes, $urandom_range(2));
    end else if (pick < 88) begin
      // Buffer too short to hold a header.
      hdr_buf[0] = 8'($urandom);
      queue_bytes(16'($urandom_range(ihv_pkg::HdrBytes - 1, 0)), 1, $urandom_range(3));
    end else if (pick < 94) begin
      // Header cut off by the next marked byte.
      queue_bytes(blen, $urandom_range(ihv_pkg::HdrBytes - 1, 1), 0);
    end else begin
      queue_bytes(16'd0, 0, $urandom_range(3, 1));
    end
  endtask

  // Sender: offers the next pending byte request unless idling or draining.
  always @(posedge clk_i or negedge rst_ni) begin : driver
    byte_slot_t slot;
    bit         waiting;
    if (!rst_ni) begin
      push     <= 1'b0;
      in_req_i <= '0;
      hdr_pos  = ihv_pkg::PosW'(ihv_pkg::HdrBytes);
      buf_len  = '0;
      clear_header();
      drv_cyc  = 0;
    end else begin
      drv_cyc++;
      waiting = push && full;
      if (push && !full) begin
        track_byte(in_req_i);
        n_accepted++;
      end
      if (!waiting) begin
        if (byte_queue.size() != 0 &&
            !(byte_queue[0].drain && header_results.size() != 0) &&
            (quiet(drv_cyc) || $urandom_range(99) >= IdlePct)) begin
          slot = byte_queue.pop_front();
          push     <= 1'b1;
          in_req_i <= slot.req;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_errors++;
    end
  endtask

  // Receiver: checks each accepted result and decides when to pop.
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    ihv_pkg::res_t want;
    if (!rst_ni) begin
      pop       <= 1'b0;
      mon_cyc   = 0;
      hold_left = 0;
    end else begin
      mon_cyc++;
      if (pop && !empty) begin
        if (header_results.size() == 0) begin
          $error("unexpected result request with status %0d", res_o.status);
          n_errors++;
        end else begin
          want = header_results.pop_front();
          n_checked++;
          status_seen[want.status]++;
          check_field("status", 32'(want.status), 32'(res_o.status));
          check_field("src_addr", want.src_addr, res_o.src_addr);
          check_field("dst_addr", want.dst_addr, res_o.dst_addr);
          check_field("protocol", 32'(want.protocol), 32'(res_o.protocol));
          check_field("hop_limit", 32'(want.hop_limit), 32'(res_o.hop_limit));
          check_field("total_length", 32'(want.total_length), 32'(res_o.total_length));
          check_field("ident", 32'(want.ident), 32'(res_o.ident));
          check_field("flags_fragment", 32'(want.flags_fragment),
                      32'(res_o.flags_fragment));
          check_field("payload_length", 32'(want.payload_length),
                      32'(res_o.payload_length));
        end
      end
      // A long hold-off lets the block fill up and stall its input.
      if (mon_cyc == HoldStart) hold_left = HoldCycles;
      if (hold_left != 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= quiet(mon_cyc) || $urandom_range(99) >= IdlePct;
      end
    end
  end

  // Watchdog on cycles in which neither side moves a request.
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WatchdogLimit) begin
      $error("no request moved for %0d cycles", WatchdogLimit);
      $display("end of test: mismatches");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Stimulus, reset and end of run.
  initial begin : stimulus
    int unsigned next_drain;
    // Empty buffer, then a stray byte while idle.
    hdr_buf[0] = 8'h00;
    queue_bytes(16'd0, 1, 1);
    // Header restarted after three bytes, then the smallest valid buffer.
    build_header(16'd20, 16'h0000);
    queue_bytes(16'd20, 3, 0);
    build_header(16'd20, 16'h0000);
    queue_bytes(16'd20, ihv_pkg::HdrBytes, 0);
    // Longest short buffer with an all-ones byte.
    hdr_buf[0] = 8'hFF;
    queue_bytes(16'd19, 1, 0);

    drain_next = 1'b1;
    next_drain = DrainEvery;
    while (byte_queue.size() < TargetBytes) begin
      if (n_useful >= next_drain) begin
        drain_next = 1'b1;
        next_drain += DrainEvery;
      end
      queue_random_buffer();
    end
    n_total = byte_queue.size();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_accepted < n_total) @(posedge clk_i);
    while (header_results.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("%0d byte requests sent, %0d header results checked", n_accepted, n_checked);
    $display("by status: ok %0d, short %0d, version %0d, length %0d, fragment %0d",
             status_seen[ihv_pkg::STATUS_OK], status_seen[ihv_pkg::STATUS_SHORT],
             status_seen[ihv_pkg::STATUS_VERSION], status_seen[ihv_pkg::STATUS_LENGTH],
             status_seen[ihv_pkg::STATUS_FRAGMENT]);
    $display("checksum %0d", status_seen[ihv_pkg::STATUS_CHECKSUM]);
    if (n_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
